>>> design/evade_pkg.sv
package evade_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgPanic = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRelax = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxW  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxV  = 2'd3;

  localparam int unsigned SqrtSteps = 25;
  localparam int unsigned DivSteps  = 48;

  typedef struct packed {
    logic               func;
    logic signed [23:0] char_x;
    logic signed [23:0] char_y;
    logic signed [23:0] char_z;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;
  } evade_req_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [15:0]        weight;
    logic               is_active;
  } evade_res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_X,
    OP_MUL_Y,
    OP_MUL_Z,
    OP_MUL_P,
    OP_MUL_L,
    OP_SAVE_L,
    OP_DONE_CHECK,
    OP_DONE_RANGE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_SEL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_STORE,
    OP_W_SAT,
    OP_DONE_STEER
  } op_e;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_W
  } sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MP,
    ST_ML,
    ST_SL,
    ST_DEC,
    ST_SQI,
    ST_SQS,
    ST_CHK,
    ST_WCHK,
    ST_VMUL,
    ST_DIVI,
    ST_DIVS,
    ST_STORE
  } state_e;

  typedef struct packed {
    op_e  op;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic s_gt_lim;
    logic root_zero;
    logic lim_zero;
  } status_t;

endpackage

>>> design/evade_ctrl.sv
module evade_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  evade_pkg::status_t  status_i,
  output evade_pkg::cmd_t     cmd_o,
  output logic                busy_o
);

  evade_pkg::state_e state_q, state_d;
  evade_pkg::sel_e   sel_q, sel_d;
  logic [5:0]        cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evade_pkg::ST_IDLE;
      sel_q   <= evade_pkg::SEL_X;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state, component select and step counter.
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      evade_pkg::ST_IDLE: if (start_i) state_d = evade_pkg::ST_MX;
      evade_pkg::ST_MX:   state_d = evade_pkg::ST_MY;
      evade_pkg::ST_MY:   state_d = evade_pkg::ST_MZ;
      evade_pkg::ST_MZ:   state_d = evade_pkg::ST_MP;
      evade_pkg::ST_MP:   state_d = evade_pkg::ST_ML;
      evade_pkg::ST_ML:   state_d = evade_pkg::ST_SL;
      evade_pkg::ST_SL:   state_d = evade_pkg::ST_DEC;
      evade_pkg::ST_DEC: begin
        if (!status_i.func || status_i.s_gt_lim) state_d = evade_pkg::ST_IDLE;
        else state_d = evade_pkg::ST_SQI;
      end
      evade_pkg::ST_SQI: begin
        state_d = evade_pkg::ST_SQS;
        cnt_d   = 6'(evade_pkg::SqrtSteps - 1);
      end
      evade_pkg::ST_SQS: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = evade_pkg::ST_CHK;
      end
      evade_pkg::ST_CHK: begin
        sel_d = evade_pkg::SEL_X;
        if (status_i.root_zero) state_d = evade_pkg::ST_WCHK;
        else state_d = evade_pkg::ST_VMUL;
      end
      evade_pkg::ST_WCHK: begin
        sel_d = evade_pkg::SEL_W;
        if (status_i.lim_zero) state_d = evade_pkg::ST_IDLE;
        else state_d = evade_pkg::ST_VMUL;
      end
      evade_pkg::ST_VMUL: state_d = evade_pkg::ST_DIVI;
      evade_pkg::ST_DIVI: begin
        state_d = evade_pkg::ST_DIVS;
        cnt_d   = 6'(evade_pkg::DivSteps - 1);
      end
      evade_pkg::ST_DIVS: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = evade_pkg::ST_STORE;
      end
      evade_pkg::ST_STORE: begin
        unique case (sel_q)
          evade_pkg::SEL_X: begin
            sel_d   = evade_pkg::SEL_Y;
            state_d = evade_pkg::ST_VMUL;
          end
          evade_pkg::SEL_Y: begin
            sel_d   = evade_pkg::SEL_Z;
            state_d = evade_pkg::ST_VMUL;
          end
          evade_pkg::SEL_Z: state_d = evade_pkg::ST_WCHK;
          evade_pkg::SEL_W: state_d = evade_pkg::ST_IDLE;
          default:          state_d = evade_pkg::ST_IDLE;
        endcase
      end
      default: state_d = evade_pkg::ST_IDLE;
    endcase
  end

  // Command to the datapath.
  always_comb begin
    cmd_o.op  = evade_pkg::OP_NONE;
    cmd_o.sel = sel_q;
    unique case (state_q)
      evade_pkg::ST_IDLE: if (start_i) cmd_o.op = evade_pkg::OP_LOAD;
      evade_pkg::ST_MX:   cmd_o.op = evade_pkg::OP_MUL_X;
      evade_pkg::ST_MY:   cmd_o.op = evade_pkg::OP_MUL_Y;
      evade_pkg::ST_MZ:   cmd_o.op = evade_pkg::OP_MUL_Z;
      evade_pkg::ST_MP:   cmd_o.op = evade_pkg::OP_MUL_P;
      evade_pkg::ST_ML:   cmd_o.op = evade_pkg::OP_MUL_L;
      evade_pkg::ST_SL:   cmd_o.op = evade_pkg::OP_SAVE_L;
      evade_pkg::ST_DEC: begin
        if (!status_i.func) cmd_o.op = evade_pkg::OP_DONE_CHECK;
        else if (status_i.s_gt_lim) cmd_o.op = evade_pkg::OP_DONE_RANGE;
      end
      evade_pkg::ST_SQI:  cmd_o.op = evade_pkg::OP_SQRT_INIT;
      evade_pkg::ST_SQS:  cmd_o.op = evade_pkg::OP_SQRT_STEP;
      evade_pkg::ST_CHK:  cmd_o.op = evade_pkg::OP_NONE;
      evade_pkg::ST_WCHK: if (status_i.lim_zero) cmd_o.op = evade_pkg::OP_W_SAT;
      evade_pkg::ST_VMUL: cmd_o.op = evade_pkg::OP_MUL_SEL;
      evade_pkg::ST_DIVI: cmd_o.op = evade_pkg::OP_DIV_INIT;
      evade_pkg::ST_DIVS: cmd_o.op = evade_pkg::OP_DIV_STEP;
      evade_pkg::ST_STORE: begin
        if (sel_q == evade_pkg::SEL_W) cmd_o.op = evade_pkg::OP_DONE_STEER;
        else cmd_o.op = evade_pkg::OP_STORE;
      end
      default: cmd_o.op = evade_pkg::OP_NONE;
    endcase
  end

  assign busy_o = (state_q != evade_pkg::ST_IDLE);

endmodule

>>> design/evade_dp.sv
module evade_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [evade_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [evade_pkg::CfgDataW-1:0]      cfg_data_i,
  input  evade_pkg::evade_req_t               req_i,
  input  evade_pkg::cmd_t                     cmd_i,
  output evade_pkg::status_t                  status_o,
  output logic                                done_o,
  output evade_pkg::evade_res_t               res_o
);

  logic [23:0] panic_q, relax_q, speed_q;
  logic [15:0] maxw_q;
  logic        flag_q;

  logic        func_q;
  logic [23:0] mag_q [3];
  logic        neg_q [3];
  logic [49:0] s_q, psq_q, lsq_q, p_q;
  logic [27:0] sr_q;
  logic [24:0] root_q;
  logic [49:0] sbits_q;
  logic [47:0] num_q, quo_q;
  logic [25:0] drem_q;
  logic [24:0] den_q;
  logic signed [23:0] vel_q [3];
  logic [15:0] w_q;
  logic        done_q;

  logic [24:0] limit;
  logic [24:0] mul_a, mul_b;
  logic [49:0] prod;
  logic [27:0] sr_n;
  logic [26:0] trial;
  logic [25:0] dr_n;
  logic [23:0] mag_sel;
  logic        neg_sel;
  logic signed [23:0] vel_sat;

  function automatic logic [24:0] diff25(input logic signed [23:0] a,
                                         input logic signed [23:0] b);
    diff25 = {a[23], a} - {b[23], b};
  endfunction

  function automatic logic [23:0] mag25(input logic [24:0] d);
    logic [24:0] m;
    m = d[24] ? (25'd0 - d) : d;
    mag25 = m[23:0];
  endfunction

  assign limit = {1'b0, panic_q} + {1'b0, relax_q};

  always_comb begin
    mag_sel = mag_q[0];
    neg_sel = neg_q[0];
    unique case (cmd_i.sel)
      evade_pkg::SEL_X: begin
        mag_sel = mag_q[0];
        neg_sel = neg_q[0];
      end
      evade_pkg::SEL_Y: begin
        mag_sel = mag_q[1];
        neg_sel = neg_q[1];
      end
      evade_pkg::SEL_Z: begin
        mag_sel = mag_q[2];
        neg_sel = neg_q[2];
      end
      evade_pkg::SEL_W: begin
        mag_sel = mag_q[2];
        neg_sel = 1'b0;
      end
      default: ;
    endcase
  end

  // One shared multiplier; its operands follow the current command.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      evade_pkg::OP_MUL_X: begin
        mul_a = {1'b0, mag_q[0]};
        mul_b = {1'b0, mag_q[0]};
      end
      evade_pkg::OP_MUL_Y: begin
        mul_a = {1'b0, mag_q[1]};
        mul_b = {1'b0, mag_q[1]};
      end
      evade_pkg::OP_MUL_Z: begin
        mul_a = {1'b0, mag_q[2]};
        mul_b = {1'b0, mag_q[2]};
      end
      evade_pkg::OP_MUL_P: begin
        mul_a = {1'b0, panic_q};
        mul_b = {1'b0, panic_q};
      end
      evade_pkg::OP_MUL_L: begin
        mul_a = limit;
        mul_b = limit;
      end
      evade_pkg::OP_MUL_SEL: begin
        if (cmd_i.sel == evade_pkg::SEL_W) begin
          mul_a = root_q;
          mul_b = {9'd0, maxw_q};
        end else begin
          mul_a = {1'b0, mag_sel};
          mul_b = {1'b0, speed_q};
        end
      end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign sr_n  = {sr_q[25:0], sbits_q[49:48]};
  assign trial = {root_q, 2'b01};
  assign dr_n  = {drem_q[24:0], num_q[47]};

  // Saturating signed velocity from the unsigned quotient.
  always_comb begin
    if (neg_sel) begin
      if (quo_q > 48'd8388608) vel_sat = 24'sh800000;
      else vel_sat = 24'(48'd0 - quo_q);
    end else begin
      if (quo_q > 48'd8388607) vel_sat = 24'sh7fffff;
      else vel_sat = 24'(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panic_q <= 24'd2560;
      relax_q <= 24'd2560;
      maxw_q  <= 16'd256;
      speed_q <= 24'd256;
      flag_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          evade_pkg::CfgPanic: panic_q <= cfg_data_i;
          evade_pkg::CfgRelax: relax_q <= cfg_data_i;
          evade_pkg::CfgMaxW:  maxw_q  <= cfg_data_i[15:0];
          evade_pkg::CfgMaxV:  speed_q <= cfg_data_i;
          default: ;
        endcase
      end
      done_q <= (cmd_i.op == evade_pkg::OP_DONE_CHECK) ||
                (cmd_i.op == evade_pkg::OP_DONE_RANGE) ||
                (cmd_i.op == evade_pkg::OP_DONE_STEER) ||
                (cmd_i.op == evade_pkg::OP_W_SAT);
      if (cmd_i.op == evade_pkg::OP_DONE_CHECK && s_q < psq_q) flag_q <= 1'b1;
      if (cmd_i.op == evade_pkg::OP_DONE_RANGE) flag_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      evade_pkg::OP_LOAD: begin
        func_q <= req_i.func;
        mag_q[0] <= mag25(diff25(req_i.char_x, req_i.target_x));
        mag_q[1] <= mag25(diff25(req_i.char_y, req_i.target_y));
        mag_q[2] <= mag25(diff25(req_i.char_z, req_i.target_z));
        neg_q[0] <= diff25(req_i.char_x, req_i.target_x) >> 24 != 25'd0;
        neg_q[1] <= diff25(req_i.char_y, req_i.target_y) >> 24 != 25'd0;
        neg_q[2] <= diff25(req_i.char_z, req_i.target_z) >> 24 != 25'd0;
        vel_q[0] <= '0;
        vel_q[1] <= '0;
        vel_q[2] <= '0;
        w_q      <= '0;
      end
      evade_pkg::OP_MUL_X: begin
        p_q <= prod;
        s_q <= '0;
      end
      evade_pkg::OP_MUL_Y, evade_pkg::OP_MUL_Z, evade_pkg::OP_MUL_P: begin
        p_q <= prod;
        s_q <= s_q + p_q;
      end
      evade_pkg::OP_MUL_L: begin
        p_q   <= prod;
        psq_q <= p_q;
      end
      evade_pkg::OP_SAVE_L: lsq_q <= p_q;
      evade_pkg::OP_SQRT_INIT: begin
        sr_q    <= '0;
        root_q  <= '0;
        sbits_q <= s_q;
      end
      evade_pkg::OP_SQRT_STEP: begin
        sbits_q <= {sbits_q[47:0], 2'b00};
        if (sr_n >= {1'b0, trial}) begin
          sr_q   <= sr_n - {1'b0, trial};
          root_q <= {root_q[23:0], 1'b1};
        end else begin
          sr_q   <= sr_n;
          root_q <= {root_q[23:0], 1'b0};
        end
      end
      evade_pkg::OP_MUL_SEL: p_q <= prod;
      evade_pkg::OP_DIV_INIT: begin
        num_q  <= p_q[47:0];
        drem_q <= '0;
        quo_q  <= '0;
        den_q  <= (cmd_i.sel == evade_pkg::SEL_W) ? limit : root_q;
      end
      evade_pkg::OP_DIV_STEP: begin
        num_q <= {num_q[46:0], 1'b0};
        if (dr_n >= {1'b0, den_q}) begin
          drem_q <= dr_n - {1'b0, den_q};
          quo_q  <= {quo_q[46:0], 1'b1};
        end else begin
          drem_q <= dr_n;
          quo_q  <= {quo_q[46:0], 1'b0};
        end
      end
      evade_pkg::OP_STORE: begin
        unique case (cmd_i.sel)
          evade_pkg::SEL_X: vel_q[0] <= vel_sat;
          evade_pkg::SEL_Y: vel_q[1] <= vel_sat;
          evade_pkg::SEL_Z: vel_q[2] <= vel_sat;
          default: ;
        endcase
      end
      evade_pkg::OP_DONE_STEER: begin
        if (quo_q > {32'd0, maxw_q}) w_q <= maxw_q;
        else w_q <= quo_q[15:0];
      end
      evade_pkg::OP_W_SAT: w_q <= maxw_q;
      default: ;
    endcase
  end

  assign status_o.func      = func_q;
  assign status_o.s_gt_lim  = (s_q > lsq_q);
  assign status_o.root_zero = (root_q == '0);
  assign status_o.lim_zero  = (limit == '0);

  assign done_o          = done_q;
  assign res_o.vel_x     = vel_q[0];
  assign res_o.vel_y     = vel_q[1];
  assign res_o.vel_z     = vel_q[2];
  assign res_o.weight    = w_q;
  assign res_o.is_active = flag_q;

endmodule

>>> design/evade_steering_with_hysteresis.sv
// Evade steering with hysteresis. A request is taken when start_i is high and busy_o is low;
// its single result appears on res_o with done_o, high for one cycle, and the receiver cannot stall
// it. A check request, and a steer request out of range, end in the decision state; a steer
// request in range goes on to a 25-step square root and four 48-step restoring divisions
// (three velocity components and the weight) sharing one divider and one 25x25 multiplier.
// A zero-length vector skips the velocity divisions, and also the weight division, saturating
// the weight, when panic plus relax distance is zero. The next request can be taken in the
// cycle that carries the result. Configuration writes take effect at once; the user must make
// them only in idle periods, as the block itself does not enforce it.
module evade_steering_with_hysteresis (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  evade_pkg::evade_req_t              req_i,
  output logic                               busy_o,
  output logic                               done_o,
  output evade_pkg::evade_res_t              res_o,
  input  logic                               cfg_we_i,
  input  logic [evade_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [evade_pkg::CfgDataW-1:0]     cfg_data_i
);

  evade_pkg::cmd_t    cmd;
  evade_pkg::status_t status;

  evade_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  evade_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_flag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o && !busy_o) |=> $stable(res_o.is_active) || done_o)
    else $error("active flag changed without a result");

endmodule

>>> test/tb_top.sv
module tb_top;
  import evade_pkg::*;

  localparam int unsigned StallLimit = 4000;

  class steer_scoreboard;
    logic [23:0] panic_d, relax_d, speed;
    logic [15:0] weight_max;
    bit          evading;
    evade_res_t  pending[$];
    int unsigned errors;

    function new();
      panic_d = 24'd2560;
      relax_d = 24'd2560;
      weight_max = 16'd256;
      speed = 24'd256;
      evading = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
      case (idx)
        CfgPanic: panic_d = val;
        CfgRelax: relax_d = val;
        CfgMaxW:  weight_max = val[15:0];
        CfgMaxV:  speed = val;
        default: ;
      endcase
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic logic [23:0] scale_axis(longint d, logic [63:0] root_d);
      logic [63:0] q;
      q = ((d < 0) ? -d : d) * {40'd0, speed} / root_d;
      if (d < 0) return (q > 64'd8388608) ? 24'h800000 : 24'(-longint'(q));
      return (q > 64'd8388607) ? 24'h7fffff : q[23:0];
    endfunction

    function void note_request(evade_req_t r);
      longint dx, dy, dz;
      logic [63:0] s, lim, root_d, w;
      evade_res_t e;
      dx = longint'(r.char_x) - longint'(r.target_x);
      dy = longint'(r.char_y) - longint'(r.target_y);
      dz = longint'(r.char_z) - longint'(r.target_z);
      s = dx * dx + dy * dy + dz * dz;
      lim = {40'd0, panic_d} + {40'd0, relax_d};
      e = '0;
      if (!r.func) begin
        if (s < {40'd0, panic_d} * {40'd0, panic_d}) evading = 1'b1;
      end else if (s > lim * lim) begin
        evading = 1'b0;
      end else begin
        root_d = root_floor(s);
        if (root_d != 0) begin
          e.vel_x = scale_axis(dx, root_d);
          e.vel_y = scale_axis(dy, root_d);
          e.vel_z = scale_axis(dz, root_d);
        end
        if (lim == 0) begin
          e.weight = weight_max;
        end else begin
          w = root_d * {48'd0, weight_max} / lim;
          e.weight = (w > weight_max) ? weight_max : w[15:0];
        end
      end
      e.is_active = evading;
      pending.push_back(e);
    endfunction

    function void check_result(evade_res_t a);
      evade_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.vel_x !== e.vel_x) begin
        $error("vel_x expected %0d got %0d", e.vel_x, a.vel_x); errors++;
      end
      if (a.vel_y !== e.vel_y) begin
        $error("vel_y expected %0d got %0d", e.vel_y, a.vel_y); errors++;
      end
      if (a.vel_z !== e.vel_z) begin
        $error("vel_z expected %0d got %0d", e.vel_z, a.vel_z); errors++;
      end
      if (a.weight !== e.weight) begin
        $error("weight expected %0d got %0d", e.weight, a.weight); errors++;
      end
      if (a.is_active !== e.is_active) begin
        $error("is_active expected %0d got %0d", e.is_active, a.is_active); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, done, cfg_we;
  evade_req_t req;
  evade_res_t res;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  steer_scoreboard sb;
  int unsigned idle_pct, requests, quiet;

  evade_steering_with_hysteresis dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (done) sb.check_result(res);
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The enable drops after each write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Start stays high after an accepted request until the next request or an idle cycle.
  task automatic send(evade_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    requests++;
  endtask

  function automatic logic [23:0] pick_coord(int unsigned spread);
    case ($urandom_range(9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom);
      default: return 24'(int'($urandom_range(2 * spread)) - int'(spread));
    endcase
  endfunction

  // Targets sit near the character most of the time so that steering stays in range.
  function automatic evade_req_t near_req(int unsigned spread);
    evade_req_t r;
    r.func = 1'($urandom_range(1));
    r.char_x = 24'($urandom);
    r.char_y = 24'($urandom);
    r.char_z = 24'($urandom);
    r.target_x = r.char_x + pick_coord(spread);
    r.target_y = r.char_y + pick_coord(spread);
    r.target_z = r.char_z + pick_coord(spread);
    if ($urandom_range(9) == 0) r.target_x = 24'($urandom);
    return r;
  endfunction

  task automatic directed();
    evade_req_t r;
    r = '0;
    send(r);
    r.func = 1'b1;
    send(r);
    r.char_x = 24'h7fffff; r.char_y = 24'h7fffff; r.char_z = 24'h7fffff;
    r.target_x = 24'h800000; r.target_y = 24'h800000; r.target_z = 24'h800000;
    send(r);
    r.func = 1'b0;
    send(r);
    r = '0; r.func = 1'b1; r.char_x = 24'd1000; r.target_y = -24'sd700;
    send(r);
    r.func = 1'b0;
    send(r);
    r.func = 1'b1; r.char_z = 24'd5000;
    send(r);
  endtask

  task automatic random_phase(int unsigned count, int unsigned spread);
    repeat (count) send(near_req(spread));
    settle();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0; start = 1'b0; req = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    idle_pct = 0; requests = 0; quiet = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    settle();
    // Huge speed saturates the velocity, zero limits exercise the weight clamp.
    write_reg(CfgMaxV, 24'hffffff);
    write_reg(CfgMaxW, 24'd65535);
    random_phase(150, 4000);
    write_reg(CfgPanic, 24'd0);
    write_reg(CfgRelax, 24'd0);
    begin
      evade_req_t z;
      z = '0; z.func = 1'b1;
      send(z);
    end
    random_phase(100, 4000);
    write_reg(CfgPanic, 24'hffffff);
    write_reg(CfgRelax, 24'hffffff);
    write_reg(CfgMaxW, 24'd0);
    write_reg(CfgMaxV, 24'd0);
    idle_pct = 81;
    random_phase(200, 8000000);
    write_reg(CfgPanic, 24'd3000);
    write_reg(CfgRelax, 24'd2000);
    write_reg(CfgMaxW, 24'd384);
    write_reg(CfgMaxV, 24'd1200);
    idle_pct = 26;
    random_phase(400, 4000);
    repeat (3) begin
      idle_pct = $urandom_range(1) ? 0 : 81;
      write_reg(CfgPanic, 24'($urandom_range(20000)));
      write_reg(CfgRelax, 24'($urandom_range(20000)));
      write_reg(CfgMaxW, 24'(16'($urandom)));
      write_reg(CfgMaxV, 24'($urandom));
      random_phase(150, 12000);
    end
    $display("Ran %0d check and steer requests across %0d register settings.", requests, 8);
    $display("Idle rates 0, 26 and 81 percent; extremes of coordinates and limits included.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/evade_pkg.sv
design/evade_ctrl.sv
design/evade_dp.sv
design/evade_steering_with_hysteresis.sv
test/tb_top.sv
